// ===== src/ptrh_pkg.sv =====
// Shared types and constants for the programming track request handshake block.
// Holds the message codes, result and command encodings used by every module.
// No dependencies.
`default_nettype none

package ptrh_pkg;

   // Default depth of the pending request queue.
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   // Depth of the command queue between the classifier and the sequencer.
   localparam int CMDQ_DEPTH = 2;

   // Bus message codes.
   localparam logic [7:0] OPC_LONG_ACK  = 8'hB4;
   localparam logic [7:0] OPC_SLOT_READ = 8'hE7;
   localparam logic [6:0] ACK_LOPC_PROG = 7'h7F;
   localparam logic [6:0] ACK_CODE_ACCEPTED = 7'h01;
   localparam logic [6:0] ACK_CODE_BLIND_OK = 7'h40;
   localparam logic [6:0] ACK_CODE_BUSY     = 7'h00;
   localparam logic [6:0] SLOT_PROGRAMMER   = 7'h7C;

   // Programmer status flag positions in a slot reply.
   localparam int STAT_NO_DECODER   = 0;
   localparam int STAT_NO_WRITE_ACK = 1;
   localparam int STAT_READ_ACK_BAD = 2;
   localparam int STAT_ABORTED      = 3;

   // Bit of the CV-high byte that carries data bit 7.
   localparam int CVH_DATA7_BIT = 1;

   // Request operations on the input channel.
   localparam logic OP_SUBMIT  = 1'b0;
   localparam logic OP_MESSAGE = 1'b1;

   typedef enum logic [1:0] {
      RSP_SEND    = 2'd0,
      RSP_DONE    = 2'd1,
      RSP_REFUSED = 2'd2
   } rsp_kind_type;

   typedef enum logic [2:0] {
      RSN_SUCCESS    = 3'd0,
      RSN_BUSY       = 3'd1,
      RSN_NOT_IMPL   = 3'd2,
      RSN_NO_DECODER = 3'd3,
      RSN_NO_WR_ACK  = 3'd4,
      RSN_RD_ACK_BAD = 3'd5,
      RSN_ABORTED    = 3'd6
   } reason_type;

   // Classified work for the sequencer.
   typedef enum logic [1:0] {
      CMD_SUBMIT    = 2'd0,  // queue or start a request
      CMD_ACK_SLOT  = 2'd1,  // acknowledge: now wait for the slot reply
      CMD_ACK_DONE  = 2'd2,  // acknowledge that completes the request
      CMD_SLOT_DONE = 2'd3   // slot reply that completes the request
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tag;
      reason_type   reason;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   tag;
      reason_type   reason;
      logic [7:0]   data;
      logic         last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/ptrh_front.sv =====
// Front end: classifies each accepted item into a sequencer command.
// Bus messages that can never match a waiting request are dropped here.
// Depends on ptrh_pkg.
`default_nettype none

module ptrh_front (
   input  wire logic             op,
   input  wire logic [7:0]       request_tag,
   input  wire logic [7:0]       msg_opcode,
   input  wire logic [6:0]       ack_lopc,
   input  wire logic [6:0]       ack_code,
   input  wire logic [6:0]       slot_number,
   input  wire logic [6:0]       prog_status,
   input  wire logic [6:0]       data_low7,
   input  wire logic [6:0]       cv_high,
   output ptrh_pkg::cmd_type     cmd,
   output logic                  keep
);
   import ptrh_pkg::*;

   always_comb begin
      cmd.kind   = CMD_SUBMIT;
      cmd.tag    = request_tag;
      cmd.reason = RSN_SUCCESS;
      cmd.data   = 8'd0;
      keep       = 1'b0;
      if (op == OP_SUBMIT) begin
         keep = 1'b1;
      end else if (msg_opcode == OPC_LONG_ACK && ack_lopc == ACK_LOPC_PROG) begin
         keep = 1'b1;
         case (ack_code)
            ACK_CODE_ACCEPTED: cmd.kind = CMD_ACK_SLOT;
            ACK_CODE_BLIND_OK: begin
               cmd.kind   = CMD_ACK_DONE;
               cmd.reason = RSN_SUCCESS;
            end
            ACK_CODE_BUSY: begin
               cmd.kind   = CMD_ACK_DONE;
               cmd.reason = RSN_BUSY;
            end
            default: begin
               cmd.kind   = CMD_ACK_DONE;
               cmd.reason = RSN_NOT_IMPL;
            end
         endcase
      end else if (msg_opcode == OPC_SLOT_READ && slot_number == SLOT_PROGRAMMER) begin
         keep     = 1'b1;
         cmd.kind = CMD_SLOT_DONE;
         // Status flags are checked lowest bit first.
         if (prog_status[STAT_NO_DECODER]) begin
            cmd.reason = RSN_NO_DECODER;
         end else if (prog_status[STAT_NO_WRITE_ACK]) begin
            cmd.reason = RSN_NO_WR_ACK;
         end else if (prog_status[STAT_READ_ACK_BAD]) begin
            cmd.reason = RSN_RD_ACK_BAD;
         end else if (prog_status[STAT_ABORTED]) begin
            cmd.reason = RSN_ABORTED;
         end else begin
            cmd.reason = RSN_SUCCESS;
            cmd.data   = {cv_high[CVH_DATA7_BIT], data_low7};
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/ptrh_cmdq.sv =====
// Short command queue between the classifier and the sequencer.
// Lets the input side keep taking items while the sequencer is stalled.
// Depends on ptrh_pkg.
`default_nettype none

module ptrh_cmdq (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire ptrh_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output ptrh_pkg::cmd_type  pop_cmd
);
   import ptrh_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/ptrh_back.sv =====
// Back end: runs one programming request at a time, keeps the pending tag
// queue and drives the registered result stage. Depends on ptrh_pkg.
`default_nettype none

module ptrh_back #(
   parameter int QUEUE_DEPTH = ptrh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  wire ptrh_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output ptrh_pkg::rsp_type  rsp
);
   import ptrh_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_WAIT_ACK  = 2'd1,
      PH_WAIT_SLOT = 2'd2
   } phase_type;

   typedef enum logic {
      ST_RUN,   // take the next command
      ST_NEXT   // issue the send for the queued request at the head
   } step_type;

   logic [7:0]       pending_ff [QUEUE_DEPTH];
   logic [7:0]       head_tag_ff;
   logic             mem_we;

   step_type         step_ff, step_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       cur_tag_ff, cur_tag_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             load_ok;
   logic             finish;
   reason_type       fin_reason;
   logic [7:0]       fin_data;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (step_ff == ST_RUN) && load_ok;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      step_in      = step_ff;
      phase_in     = phase_ff;
      cur_tag_in   = cur_tag_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      finish       = 1'b0;
      fin_reason   = cmd.reason;
      fin_data     = 8'd0;

      case (step_ff)
         ST_RUN: begin
            if (cmd_valid && load_ok) begin
               case (cmd.kind)
                  CMD_SUBMIT: begin
                     if (phase_ff != PH_WAIT_ACK && phase_ff != PH_WAIT_SLOT) begin
                        // The queue is always empty when idle: start at once.
                        cur_tag_in   = cmd.tag;
                        phase_in     = PH_WAIT_ACK;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{RSP_SEND, cmd.tag, RSN_SUCCESS, 8'd0, 1'b1};
                     end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{RSP_REFUSED, cmd.tag, RSN_SUCCESS, 8'd0, 1'b1};
                     end else begin
                        mem_we   = 1'b1;
                        tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_ACK_SLOT: begin
                     if (phase_ff == PH_WAIT_ACK) begin
                        phase_in = PH_WAIT_SLOT;
                     end
                  end
                  CMD_ACK_DONE: begin
                     finish = (phase_ff == PH_WAIT_ACK);
                  end
                  CMD_SLOT_DONE: begin
                     finish   = (phase_ff == PH_WAIT_SLOT);
                     fin_data = cmd.data;
                  end
                  default: ;
               endcase

               if (finish) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{RSP_DONE, cur_tag_ff, fin_reason, fin_data,
                                   count_ff == '0};
                  if (count_ff == '0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     step_in = ST_NEXT;
                  end
               end
            end
         end
         ST_NEXT: begin
            if (load_ok) begin
               cur_tag_in   = head_tag_ff;
               phase_in     = PH_WAIT_ACK;
               head_in      = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{RSP_SEND, head_tag_ff, RSN_SUCCESS, 8'd0, 1'b1};
               step_in      = ST_RUN;
            end
         end
         default: step_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_RUN;
         phase_ff     <= PH_IDLE;
         cur_tag_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         cur_tag_ff   <= cur_tag_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Pending tag memory: one write port at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pending_ff[tail_ff] <= cmd.tag;
      end
      head_tag_ff <= pending_ff[head_ff];
   end

endmodule

`default_nettype wire

// ===== src/programming_track_request_handshake.sv =====
// Top level of the service-mode programming request handshake controller.
// Instantiates ptrh_front, ptrh_cmdq and ptrh_back; depends on ptrh_pkg.
`default_nettype none

// Programming requests are submitted by tag (req_tuser = 0) and run one at a
// time; bus messages (req_tuser = 1) drive the running request forward. Each
// started request produces a send transfer on the rsp channel; a long
// acknowledge for the programmer either completes it or moves it on to wait
// for the programmer slot reply, whose status flags decide the completion
// reason. A completion is immediately followed by the send transfer of the
// next queued request, if any, and rsp_tlast marks the last transfer caused
// by one input. A submit into a full queue gets a single refused transfer.
// Messages that do not fit the current wait are dropped without a result.
// The input side accepts one transfer per cycle while the two-entry command
// queue has room; the sequencer handles one command per cycle while its
// result register can be loaded, except that a completion with a queued
// follower passes through ST_NEXT to send the queued tag. A result waiting
// on rsp_tready does not stop the input side until the command queue fills.
// There is no configuration and no clearing pass after reset.

module programming_track_request_handshake #(
   parameter int QUEUE_DEPTH = ptrh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata from bit 0: request_tag[7:0], msg_opcode[15:8], ack_lopc[22:16],
   // ack_code[29:23], slot_number[36:30], prog_status[43:37],
   // data_low7[50:44], cv_high[57:51], zero fill [63:58]
   input  wire logic [63:0] req_tdata,
   // req_tuser: op (0 submit request, 1 bus message)
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata from bit 0: out_tag[7:0], completion_reason[10:8],
   // read_data[18:11], zero fill [23:19]
   output logic [23:0]      rsp_tdata,
   // rsp_tuser: out_kind[1:0] (0 send, 1 completed, 2 refused)
   output logic [1:0]       rsp_tuser,
   // rsp_tlast: last result caused by one input
   output logic             rsp_tlast
);
   import ptrh_pkg::*;

   cmd_type front_cmd;
   logic    front_keep;
   logic    q_push_ready;
   logic    q_pop_valid;
   logic    q_pop_ready;
   cmd_type q_pop_cmd;
   rsp_type back_rsp;

   ptrh_front u_front (
      .op          (req_tuser),
      .request_tag (req_tdata[7:0]),
      .msg_opcode  (req_tdata[15:8]),
      .ack_lopc    (req_tdata[22:16]),
      .ack_code    (req_tdata[29:23]),
      .slot_number (req_tdata[36:30]),
      .prog_status (req_tdata[43:37]),
      .data_low7   (req_tdata[50:44]),
      .cv_high     (req_tdata[57:51]),
      .cmd         (front_cmd),
      .keep        (front_keep)
   );

   // Dropped messages are still taken from the bus, so ready only follows
   // the queue.
   assign req_tready = q_push_ready;

   ptrh_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid && front_keep),
      .push_ready (q_push_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_cmd    (q_pop_cmd)
   );

   ptrh_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_pop_valid),
      .cmd_ready (q_pop_ready),
      .cmd       (q_pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (back_rsp)
   );

   assign rsp_tdata = {5'd0, back_rsp.data, back_rsp.reason, back_rsp.tag};
   assign rsp_tuser = back_rsp.kind;
   assign rsp_tlast = back_rsp.last;

endmodule

`default_nettype wire
